// ===== rtl/core/mptrie_pkg.sv =====
// ----------------------------------------------------------------------------
// Multipath stride trie package
// Shared constants, operation and status codes, and the request and result
// types of the longest-prefix-match engine.
// ----------------------------------------------------------------------------
package mptrie_pkg;

  localparam int NODE_POOL     = 4096;
  localparam int MAX_HOPS      = 7;
  localparam int MAX_SETS      = 255;
  localparam int ROUTE_ID_BITS = 16;
  localparam int KEY_W         = ROUTE_ID_BITS + 8;
  localparam int CHILD_W       = 13;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_HOP_WR = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXISTS     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [1:0] ST_POOL_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] dest_addr;
    logic [31:0] prefix_mask;
    logic [15:0] route_id;
    logic [7:0]  set_index;
    logic        replace;
    logic [31:0] flow_hash;
    logic [2:0]  hop_pos;
    logic [2:0]  hop_count;
    logic [31:0] hop_gw;
    logic [7:0]  hop_port;
  } in_item_t;

  typedef struct packed {
    logic        port_valid;
    logic [7:0]  out_port;
    logic [31:0] out_gw;
    logic [15:0] prev_route_id;
    logic [7:0]  prev_set_index;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      addr;
    logic [31:0]      mask;
    logic [KEY_W-1:0] key;
    logic             repl;
  } trie_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       status;
  } trie_rsp_t;

  typedef struct packed {
    logic        wr;
    logic [7:0]  set;
    logic [2:0]  pos;
    logic [2:0]  cnt;
    logic [31:0] gw;
    logic [7:0]  port;
    logic [31:0] hash;
  } hop_req_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  port;
    logic [31:0] gw;
  } hop_rsp_t;

endpackage

// ===== rtl/core/mptrie_hop.sv =====
// ----------------------------------------------------------------------------
// Next-hop selector
// Holds the hop tables, takes hop table writes, and picks one hop of a set
// with an iterative flow hash remainder, four hash bits per cycle.
// ----------------------------------------------------------------------------
module mptrie_hop (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mptrie_pkg::hop_req_t req,
  output logic                 done,
  output mptrie_pkg::hop_rsp_t rsp
);
  import mptrie_pkg::*;

  localparam int HOP_DEPTH = MAX_SETS * MAX_HOPS;
  localparam int HOP_AW    = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1;
  localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  typedef enum logic [2:0] {H_IDLE, H_CNT, H_MOD, H_RD, H_OUT} hstate_t;

  hstate_t     state_r, state_nxt;
  logic        done_r, done_nxt;
  hop_rsp_t    rsp_r, rsp_nxt;
  logic [7:0]  set_r, set_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [2:0]  c_r, c_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [2:0]  step_r, step_nxt;

  logic [2:0]  cnt_mem [MAX_SETS];
  logic [31:0] gw_mem [HOP_DEPTH];
  logic [7:0]  port_mem [HOP_DEPTH];
  logic [2:0]  cnt_rd_r;
  logic [31:0] gw_rd_r;
  logic [7:0]  port_rd_r;

  logic              cnt_we, hop_we;
  logic [SET_AW-1:0] cnt_a;
  logic [2:0]        cnt_wd;
  logic [HOP_AW-1:0] hop_wa, hop_ra;
  logic [2:0]        rem_step;

  always_comb begin
    logic [3:0] t;
    logic [2:0] r;
    r = rem_r;
    for (int k = 0; k < 4; k++) begin
      t = {r, hash_r[31-k]};
      if (t >= {1'b0, c_r}) begin
        t = t - {1'b0, c_r};
      end
      r = t[2:0];
    end
    rem_step = r;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    rsp_nxt   = rsp_r;
    set_nxt   = set_r;
    hash_nxt  = hash_r;
    c_nxt     = c_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    cnt_we    = 1'b0;
    hop_we    = 1'b0;
    cnt_a     = SET_AW'(int'(req.set) - 1);
    cnt_wd    = (int'(req.cnt) > MAX_HOPS) ? 3'(MAX_HOPS) : req.cnt;
    hop_wa    = HOP_AW'((int'(req.set) - 1) * MAX_HOPS + int'(req.pos));
    hop_ra    = HOP_AW'((int'(set_r) - 1) * MAX_HOPS + int'(rem_r));
    case (state_r)
      H_IDLE: begin
        if (start) begin
          rsp_nxt  = '0;
          set_nxt  = req.set;
          hash_nxt = req.hash;
          if (req.wr) begin
            if (req.set != 8'd0 && int'(req.set) <= MAX_SETS && int'(req.pos) < MAX_HOPS) begin
              cnt_we = 1'b1;
              hop_we = 1'b1;
            end
            done_nxt = 1'b1;
          end else if (req.set != 8'd0 && int'(req.set) <= MAX_SETS) begin
            state_nxt = H_CNT;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
      H_CNT: begin
        if (cnt_rd_r == 3'd0) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          c_nxt     = cnt_rd_r;
          rem_nxt   = 3'd0;
          step_nxt  = 3'd0;
          state_nxt = H_MOD;
        end
      end
      H_MOD: begin
        rem_nxt  = rem_step;
        hash_nxt = {hash_r[27:0], 4'd0};
        step_nxt = step_r + 3'd1;
        if (&step_r) begin
          state_nxt = H_RD;
        end
      end
      H_RD: begin
        state_nxt = H_OUT;
      end
      H_OUT: begin
        rsp_nxt.valid = 1'b1;
        rsp_nxt.port  = port_rd_r;
        rsp_nxt.gw    = gw_rd_r;
        done_nxt      = 1'b1;
        state_nxt     = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp_r  <= rsp_nxt;
    set_r  <= set_nxt;
    hash_r <= hash_nxt;
    c_r    <= c_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_a] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[cnt_a];
  end

  always_ff @(posedge clk) begin
    if (hop_we) begin
      gw_mem[hop_wa]   <= req.gw;
      port_mem[hop_wa] <= req.port;
    end
    gw_rd_r   <= gw_mem[hop_ra];
    port_rd_r <= port_mem[hop_ra];
  end

  assign done = done_r;
  assign rsp  = rsp_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == H_IDLE) else $error("hop request while busy");
  a_mod_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == H_CNT && cnt_rd_r != 3'd0) |=> (state_r == H_MOD && step_r == 3'd0))
    else $error("remainder did not start");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == H_RD |-> rem_r < c_r) else $error("remainder out of range");
`endif

endmodule

// ===== rtl/core/mptrie_trie.sv =====
// ----------------------------------------------------------------------------
// Stride trie store and walker
// Holds the key and child memories of the root and pool nodes, walks them
// for lookups, and expands or restores prefixes for inserts and removes.
// ----------------------------------------------------------------------------
module mptrie_trie (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mptrie_pkg::trie_req_t req,
  output logic                  ready,
  output logic                  done,
  output mptrie_pkg::trie_rsp_t rsp
);
  import mptrie_pkg::*;

  localparam int NODE_BITS = $clog2(NODE_POOL);
  localparam int ROOT_IW   = 17;
  localparam int SUB_IW    = 5;
  localparam int KEY_LAW   = (ROOT_IW > NODE_BITS + SUB_IW) ? ROOT_IW : NODE_BITS + SUB_IW;
  localparam int KEY_AW    = KEY_LAW + 1;
  localparam int CH_LAW    = (16 > NODE_BITS + 4) ? 16 : NODE_BITS + 4;
  localparam int CH_AW     = CH_LAW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LK_RD, S_LK_CHK, S_UP_DESC, S_UP_CHILD,
    S_UP_GRAB, S_UP_LINK, S_UP_RD1, S_UP_RD2, S_UP_SWEEP
  } tstate_t;

  function automatic logic [KEY_AW-1:0] key_addr(logic [NODE_BITS-1:0] nd,
                                                 logic [ROOT_IW-1:0] i);
    if (nd == '0) begin
      key_addr = {1'b0, KEY_LAW'(i)};
    end else begin
      key_addr = {1'b1, KEY_LAW'({nd, i[SUB_IW-1:0]})};
    end
  endfunction

  function automatic logic [CH_AW-1:0] child_addr(logic [NODE_BITS-1:0] nd,
                                                  logic [15:0] i);
    if (nd == '0) begin
      child_addr = {1'b0, CH_LAW'(i)};
    end else begin
      child_addr = {1'b1, CH_LAW'({nd, i[3:0]})};
    end
  endfunction

  tstate_t              state_r, state_nxt;
  trie_req_t            req_r, req_nxt;
  trie_rsp_t            rsp_r, rsp_nxt;
  logic                 done_r, done_nxt;
  logic [NODE_BITS-1:0] node_r, node_nxt;
  logic [NODE_BITS-1:0] new_r, new_nxt;
  logic [2:0]           level_r, level_nxt;
  logic [KEY_W-1:0]     cur_r, cur_nxt;
  logic [KEY_W-1:0]     dflt_r, dflt_nxt;
  logic [CHILD_W-1:0]   free_r, free_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [CH_AW-1:0]     par_a_r, par_a_nxt;
  logic [ROOT_IW-1:0]   i1_r, i1_nxt;
  logic [KEY_W-1:0]     rep_r, rep_nxt;
  logic [KEY_W-1:0]     nkey_r, nkey_nxt;
  logic [17:0]          x_r, x_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic                 iss_r, iss_nxt, pend_r, pend_nxt;
  logic [ROOT_IW-1:0]   pend_a_r, pend_a_nxt;
  logic [16:0]          clr_r, clr_nxt;

  logic [KEY_W-1:0]   key_mem [2**KEY_AW];
  logic [CHILD_W-1:0] ch_mem [2**CH_AW];
  logic [KEY_W-1:0]   key_rd_r;
  logic [CHILD_W-1:0] ch_rd_r;

  logic               key_we, ch_we;
  logic [KEY_AW-1:0]  key_wa, key_ra;
  logic [KEY_W-1:0]   key_wd;
  logic [CH_AW-1:0]   ch_wa, ch_ra;
  logic [CHILD_W-1:0] ch_wd;

  logic [15:0]        idx, mfield;
  logic               low_nz;
  logic [ROOT_IW-1:0] leaf_i, i1, nm;
  logic [4:0]         h;
  logic [KEY_W-1:0]   old_key, upd_key, lk_cur;
  logic               rid_nz, dflt_nz, apply, ch_none;
  logic [1:0]         up_st;
  logic [17:0]        lim, lo2;

  always_comb begin
    idx    = '0;
    mfield = '0;
    low_nz = 1'b0;
    case (level_r)
      3'd0: begin
        idx    = req_r.addr[31:16];
        mfield = req_r.mask[31:16];
        low_nz = |req_r.mask[15:0];
      end
      3'd1: begin
        idx    = 16'(req_r.addr[15:12]);
        mfield = 16'(req_r.mask[15:12]);
        low_nz = |req_r.mask[11:0];
      end
      3'd2: begin
        idx    = 16'(req_r.addr[11:8]);
        mfield = 16'(req_r.mask[11:8]);
        low_nz = |req_r.mask[7:0];
      end
      3'd3: begin
        idx    = 16'(req_r.addr[7:4]);
        mfield = 16'(req_r.mask[7:4]);
        low_nz = |req_r.mask[3:0];
      end
      3'd4: begin
        idx    = 16'(req_r.addr[3:0]);
        mfield = 16'(req_r.mask[3:0]);
      end
      default: ;
    endcase
    if (level_r == 3'd0) begin
      leaf_i = {1'b1, idx};
      nm     = 17'h10000 - {1'b0, mfield};
    end else begin
      leaf_i = ROOT_IW'({1'b1, idx[3:0]});
      nm     = 17'd16 - ROOT_IW'(mfield[3:0]);
    end
    h = '0;
    for (int b = 0; b < ROOT_IW; b++) begin
      if (nm[b]) begin
        h = 5'(b);
      end
    end
    i1 = leaf_i >> h;
  end

  always_comb begin
    old_key = (rep_r != '0 && i1_r > 17'd3 && key_rd_r == rep_r) ? '0 : rep_r;
    upd_key = (req_r.op == OP_INSERT) ? req_r.key : '0;
    if (upd_key == '0 && i1_r > 17'd3) begin
      upd_key = key_rd_r;
    end
    rid_nz  = |old_key[ROUTE_ID_BITS-1:0];
    dflt_nz = |dflt_r[ROUTE_ID_BITS-1:0];
    if (req_r.op == OP_INSERT) begin
      apply = (old_key != upd_key) && (old_key == '0 || req_r.repl);
      up_st = (rid_nz && !req_r.repl) ? ST_EXISTS : ST_OK;
    end else begin
      apply = rid_nz && (old_key != upd_key);
      up_st = rid_nz ? ST_OK : ST_NOT_FOUND;
    end
    lk_cur  = (key_rd_r != '0) ? key_rd_r : cur_r;
    ch_none = (ch_rd_r == '0) || (int'(ch_rd_r) >= NODE_POOL);
    lim     = (node_r == '0) ? 18'h20000 : 18'd32;
    lo2     = {lo_r[16:0], 1'b0};
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    rsp_nxt    = rsp_r;
    done_nxt   = 1'b0;
    node_nxt   = node_r;
    new_nxt    = new_r;
    level_nxt  = level_r;
    cur_nxt    = cur_r;
    dflt_nxt   = dflt_r;
    free_nxt   = free_r;
    cnt_nxt    = cnt_r;
    par_a_nxt  = par_a_r;
    i1_nxt     = i1_r;
    rep_nxt    = rep_r;
    nkey_nxt   = nkey_r;
    x_nxt      = x_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    iss_nxt    = iss_r;
    pend_nxt   = pend_r;
    pend_a_nxt = pend_a_r;
    clr_nxt    = clr_r;
    key_we     = 1'b0;
    key_wa     = key_addr(node_r, pend_a_r);
    key_wd     = '0;
    key_ra     = key_addr(node_r, leaf_i);
    ch_we      = 1'b0;
    ch_wa      = par_a_r;
    ch_wd      = '0;
    ch_ra      = child_addr(node_r, idx);
    case (state_r)
      S_CLEAR: begin
        key_we  = 1'b1;
        key_wa  = {1'b0, KEY_LAW'(clr_r)};
        ch_we   = 1'b1;
        ch_wa   = {1'b0, CH_LAW'(clr_r[15:0])};
        clr_nxt = clr_r + 17'd1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = req;
          node_nxt  = '0;
          level_nxt = 3'd0;
          if (req.op == OP_LOOKUP) begin
            cur_nxt   = dflt_r;
            state_nxt = S_LK_RD;
          end else if (req.op != OP_INSERT && req.op != OP_REMOVE) begin
            rsp_nxt  = '0;
            done_nxt = 1'b1;
          end else if (req.mask == 32'd0) begin
            rsp_nxt.key = dflt_r;
            done_nxt    = 1'b1;
            if (req.op == OP_INSERT) begin
              if (!dflt_nz || req.repl) begin
                dflt_nxt = req.key;
              end
              rsp_nxt.status = (dflt_nz && !req.repl) ? ST_EXISTS : ST_OK;
            end else begin
              if (dflt_nz) begin
                dflt_nxt = '0;
              end
              rsp_nxt.status = dflt_nz ? ST_OK : ST_NOT_FOUND;
            end
          end else begin
            state_nxt = S_UP_DESC;
          end
        end
      end
      S_LK_RD: begin
        state_nxt = S_LK_CHK;
      end
      S_LK_CHK: begin
        cur_nxt = lk_cur;
        if (ch_none || level_r == 3'd4) begin
          rsp_nxt.key    = lk_cur;
          rsp_nxt.status = ST_OK;
          done_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          node_nxt  = ch_rd_r[NODE_BITS-1:0];
          level_nxt = level_r + 3'd1;
          state_nxt = S_LK_RD;
        end
      end
      S_UP_DESC: begin
        if (level_r < 3'd4 && low_nz) begin
          state_nxt = S_UP_CHILD;
        end else begin
          i1_nxt    = i1;
          key_ra    = key_addr(node_r, i1);
          state_nxt = S_UP_RD1;
        end
      end
      S_UP_CHILD: begin
        if (ch_none) begin
          if (req_r.op == OP_REMOVE) begin
            rsp_nxt.key    = '0;
            rsp_nxt.status = ST_NOT_FOUND;
            done_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end else if (int'(free_r) >= NODE_POOL) begin
            rsp_nxt.key    = '0;
            rsp_nxt.status = ST_POOL_EMPTY;
            done_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            new_nxt   = free_r[NODE_BITS-1:0];
            free_nxt  = free_r + CHILD_W'(1);
            cnt_nxt   = 5'd0;
            par_a_nxt = child_addr(node_r, idx);
            state_nxt = S_UP_GRAB;
          end
        end else begin
          node_nxt  = ch_rd_r[NODE_BITS-1:0];
          level_nxt = level_r + 3'd1;
          state_nxt = S_UP_DESC;
        end
      end
      S_UP_GRAB: begin
        key_we  = 1'b1;
        key_wa  = key_addr(new_r, ROOT_IW'(cnt_r));
        ch_we   = 1'b1;
        ch_wa   = child_addr(new_r, 16'(cnt_r[3:0]));
        cnt_nxt = cnt_r + 5'd1;
        if (&cnt_r) begin
          state_nxt = S_UP_LINK;
        end
      end
      S_UP_LINK: begin
        ch_we     = 1'b1;
        ch_wa     = par_a_r;
        ch_wd     = CHILD_W'(new_r);
        node_nxt  = new_r;
        level_nxt = level_r + 3'd1;
        state_nxt = S_UP_DESC;
      end
      S_UP_RD1: begin
        rep_nxt   = key_rd_r;
        key_ra    = key_addr(node_r, i1_r >> 1);
        state_nxt = S_UP_RD2;
      end
      S_UP_RD2: begin
        rsp_nxt.key    = old_key;
        rsp_nxt.status = up_st;
        if (apply) begin
          nkey_nxt  = upd_key;
          x_nxt     = {1'b0, i1_r};
          lo_nxt    = {1'b0, i1_r};
          hi_nxt    = {1'b0, i1_r};
          iss_nxt   = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_UP_SWEEP;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_UP_SWEEP: begin
        if (pend_r && key_rd_r == rep_r && pend_a_r >= 17'd2) begin
          key_we = 1'b1;
          key_wa = key_addr(node_r, pend_a_r);
          key_wd = nkey_r;
        end
        if (iss_r) begin
          key_ra     = key_addr(node_r, x_r[ROOT_IW-1:0]);
          pend_nxt   = 1'b1;
          pend_a_nxt = x_r[ROOT_IW-1:0];
          if (x_r == hi_r) begin
            if (lo2 >= lim) begin
              iss_nxt = 1'b0;
            end else begin
              x_nxt  = lo2;
              lo_nxt = lo2;
              hi_nxt = {hi_r[16:0], 1'b1};
            end
          end else begin
            x_nxt = x_r + 18'd1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rsp_r    <= rsp_nxt;
    node_r   <= node_nxt;
    new_r    <= new_nxt;
    level_r  <= level_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    par_a_r  <= par_a_nxt;
    i1_r     <= i1_nxt;
    rep_r    <= rep_nxt;
    nkey_r   <= nkey_nxt;
    x_r      <= x_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    iss_r    <= iss_nxt;
    pend_r   <= pend_nxt;
    pend_a_r <= pend_a_nxt;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      done_r  <= 1'b0;
      dflt_r  <= '0;
      free_r  <= CHILD_W'(1);
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      dflt_r  <= dflt_nxt;
      free_r  <= free_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_r <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_wa] <= ch_wd;
    end
    ch_rd_r <= ch_mem[ch_ra];
  end

  assign ready = (state_r == S_IDLE);
  assign done  = done_r;
  assign rsp   = rsp_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE) else $error("trie request while busy");
  a_free_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> free_r >= $past(free_r)) else $error("free node count fell");
  a_grab_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_GRAB |-> (new_r != '0 && int'(free_r) <= NODE_POOL))
    else $error("node taken beyond pool");
  a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !done_r) else $error("result during clearing");
`endif

endmodule

// ===== rtl/core/multipath_ipv4_stride_trie_core.sv =====
// ----------------------------------------------------------------------------
// Multipath IPv4 stride trie core
// Longest-prefix-match engine with a 16,4,4,4,4 stride trie and next-hop
// set selection by flow hash.
// ----------------------------------------------------------------------------
// After reset the core clears the root node memories and accepts no
// request until that pass is done. A lookup visits one to five trie
// levels, each with a registered read of the key and child memories, then
// the hop table: a count read, a remainder taken over the flow hash four
// bits at a time, and a hop read. An insert or remove descends one level at
// a time, clears each pool node it takes, reads the target and parent keys,
// and then rewrites the expanded subtree at one key per cycle: about twice
// the number of leaves the prefix covers, up to 65535 keys for a one-bit
// prefix in the root node. One request is processed at a time; the next
// request is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module multipath_ipv4_stride_trie_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mptrie_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mptrie_pkg::out_item_t out_data
);
  import mptrie_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_TRIE, T_HOP, T_DONE} cstate_t;

  cstate_t   state_r, state_nxt;
  in_item_t  req_r, req_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      tstart_r, tstart_nxt;
  logic      hstart_r, hstart_nxt;
  logic [7:0] lk_set_r, lk_set_nxt;

  trie_req_t treq;
  trie_rsp_t trsp;
  hop_req_t  hreq;
  hop_rsp_t  hrsp;
  logic      t_ready, t_done, h_done, accept;

  assign treq.op   = req_r.op;
  assign treq.addr = req_r.dest_addr;
  assign treq.mask = req_r.prefix_mask;
  assign treq.key  = {req_r.set_index, ROUTE_ID_BITS'(req_r.route_id)};
  assign treq.repl = req_r.replace;

  assign hreq.wr   = (req_r.op == OP_HOP_WR);
  assign hreq.set  = (req_r.op == OP_HOP_WR) ? req_r.set_index : lk_set_r;
  assign hreq.pos  = req_r.hop_pos;
  assign hreq.cnt  = req_r.hop_count;
  assign hreq.gw   = req_r.hop_gw;
  assign hreq.port = req_r.hop_port;
  assign hreq.hash = req_r.flow_hash;

  mptrie_trie u_trie (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tstart_r),
    .req   (treq),
    .ready (t_ready),
    .done  (t_done),
    .rsp   (trsp)
  );

  mptrie_hop u_hop (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hstart_r),
    .req   (hreq),
    .done  (h_done),
    .rsp   (hrsp)
  );

  assign in_ready = (state_r == T_IDLE) && t_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    tstart_nxt    = 1'b0;
    hstart_nxt    = 1'b0;
    lk_set_nxt    = lk_set_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          if (in_data.op == OP_HOP_WR) begin
            hstart_nxt = 1'b1;
            state_nxt  = T_HOP;
          end else begin
            tstart_nxt = 1'b1;
            state_nxt  = T_TRIE;
          end
        end
      end
      T_TRIE: begin
        if (t_done) begin
          if (req_r.op == OP_LOOKUP) begin
            lk_set_nxt = trsp.key[KEY_W-1:ROUTE_ID_BITS];
            hstart_nxt = 1'b1;
            state_nxt  = T_HOP;
          end else begin
            res_nxt                = '0;
            res_nxt.prev_route_id  = 16'(trsp.key[ROUTE_ID_BITS-1:0]);
            res_nxt.prev_set_index = trsp.key[KEY_W-1:ROUTE_ID_BITS];
            res_nxt.status         = trsp.status;
            state_nxt              = T_DONE;
          end
        end
      end
      T_HOP: begin
        if (h_done) begin
          res_nxt = '0;
          if (req_r.op == OP_LOOKUP) begin
            res_nxt.port_valid = hrsp.valid;
            res_nxt.out_port   = hrsp.port;
            res_nxt.out_gw     = hrsp.gw;
          end
          state_nxt = T_DONE;
        end
      end
      T_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    lk_set_r   <= lk_set_nxt;
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      tstart_r    <= 1'b0;
      hstart_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tstart_r    <= tstart_nxt;
      hstart_r    <= hstart_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(tstart_r && hstart_r)) else $error("two units started together");
  a_trie_start: assert property (@(posedge clk) disable iff (!rst_n)
    tstart_r |-> state_r == T_TRIE) else $error("trie started out of sequence");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DONE && out_valid_r && !out_ready) |=> state_r == T_DONE)
    else $error("result dropped while output busy");
`endif

endmodule

// ===== sim/tb_multipath_ipv4_stride_trie_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stride trie core testbench
// Drives lookup, insert, remove and hop table requests through the valid and
// ready channels; checks each result against a behavioral trie and hop table
// in the bench or a result typed in the directed table. Hop writes come first,
// then a directed table, random traffic, host routes that drain the node pool.
// ----------------------------------------------------------------------------
module tb_multipath_ipv4_stride_trie_core;
  import mptrie_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  multipath_ipv4_stride_trie_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] mask;
  } prefix_t;

  // Trie and hop table mirror.
  bit [KEY_W-1:0]   root_leaf[65536];
  bit [KEY_W-1:0]   root_inner[65536];
  bit [CHILD_W-1:0] root_child[65536];
  bit [KEY_W-1:0]   pool_leaf[NODE_POOL*16];
  bit [KEY_W-1:0]   pool_inner[NODE_POOL*14];
  bit [CHILD_W-1:0] pool_child[NODE_POOL*16];
  int unsigned      free_node;
  bit [KEY_W-1:0]   default_route;
  bit [31:0]        hop_gw_tab[MAX_SETS*MAX_HOPS];
  bit [7:0]         hop_port_tab[MAX_SETS*MAX_HOPS];
  bit [2:0]         hop_cnt_tab[MAX_SETS];

  out_item_t   pending_results[$];
  prefix_t     known_prefixes[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  live_sets[$];
  bit          idle_on;
  bit          pool_full_seen;
  int          errs;
  int          n_req;
  int          n_hits;
  int          n_updates;
  int          n_pool_full;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit [KEY_W-1:0] key_at(int unsigned nd, int unsigned i);
    if (nd == 0) begin
      if (i >= 65536) return root_leaf[i-65536];
      if (i >= 2) return root_inner[i-2];
      return '0;
    end
    if (i >= 16) return pool_leaf[nd*16+i-16];
    if (i >= 2) return pool_inner[nd*14+i-2];
    return '0;
  endfunction

  function automatic void put_key(int unsigned nd, int unsigned i, bit [KEY_W-1:0] k);
    if (nd == 0) begin
      if (i >= 65536) root_leaf[i-65536] = k;
      else if (i >= 2) root_inner[i-2] = k;
    end else begin
      if (i >= 16) pool_leaf[nd*16+i-16] = k;
      else if (i >= 2) pool_inner[nd*14+i-2] = k;
    end
  endfunction

  function automatic bit [CHILD_W-1:0] child_at(int unsigned nd, int unsigned i);
    return (nd == 0) ? root_child[i] : pool_child[nd*16+i];
  endfunction

  // Descends to the node holding the prefix, then expands the new key over
  // every slot of the prefix subtree that still carries the old one.
  function automatic logic [1:0] expand_prefix(logic [31:0] addr, logic [31:0] mask,
                                               bit [KEY_W-1:0] key, bit repl, bit grow,
                                               bit apply, output bit [KEY_W-1:0] prev);
    int unsigned      nd;
    int unsigned      lvl;
    int unsigned      sh;
    int unsigned      fan;
    int unsigned      i1;
    int unsigned      nm;
    int unsigned      x;
    bit [CHILD_W-1:0] ch;
    bit [KEY_W-1:0]   rep;
    bit [KEY_W-1:0]   old;
    nd   = 0;
    lvl  = 0;
    prev = '0;
    while (1) begin
      sh  = 16 - 4 * lvl;
      fan = (lvl == 0) ? 65536 : 16;
      i1  = (addr >> sh) & (fan - 1);
      if (lvl < 4 && (mask & ((32'd1 << sh) - 1)) != 0) begin
        ch = child_at(nd, i1);
        if (ch == 0) begin
          if (!grow) return ST_NOT_FOUND;
          if (free_node >= NODE_POOL) return ST_POOL_EMPTY;
          ch = free_node++;
          for (int j = 0; j < 16; j++) begin
            pool_leaf[ch*16+j]  = '0;
            pool_child[ch*16+j] = '0;
          end
          for (int j = 0; j < 14; j++) pool_inner[ch*14+j] = '0;
          if (nd == 0) root_child[i1] = ch;
          else pool_child[nd*16+i1] = ch;
        end
        nd = ch;
        lvl++;
      end else begin
        break;
      end
    end
    i1 = fan + i1;
    nm = fan - ((mask >> sh) & (fan - 1));
    for (x = nm; x > 1; x = x / 2) i1 = i1 / 2;
    rep = key_at(nd, i1);
    old = rep;
    if (old != 0 && i1 > 3 && key_at(nd, i1 / 2) == old) old = '0;
    if (key == 0 && i1 > 3) key = key_at(nd, i1 / 2);
    prev = old;
    if (apply && old != key && (old == 0 || repl)) begin
      for (nm = 1; i1 < 2 * fan; i1 = i1 * 2, nm = nm * 2)
        for (x = i1; x < i1 + nm; x++)
          if (key_at(nd, x) == rep) put_key(nd, x, key);
    end
    return ST_OK;
  endfunction

  function automatic out_item_t route_result(in_item_t it);
    out_item_t      r;
    bit [KEY_W-1:0] newkey;
    bit [KEY_W-1:0] prev;
    bit [KEY_W-1:0] cur;
    bit [KEY_W-1:0] k;
    bit [KEY_W-1:0] scratch;
    bit [CHILD_W-1:0] ch;
    logic [1:0]     st;
    logic [1:0]     rc;
    int unsigned    nd;
    int unsigned    lvl;
    int unsigned    fan;
    int unsigned    idx;
    int unsigned    s;
    int unsigned    c;
    int unsigned    hi;
    r      = '0;
    prev   = '0;
    st     = ST_OK;
    newkey = {it.set_index, it.route_id};
    case (it.op)
      OP_LOOKUP: begin
        cur = default_route;
        nd  = 0;
        lvl = 0;
        while (1) begin
          fan = (lvl == 0) ? 65536 : 16;
          idx = (it.dest_addr >> (16 - 4 * lvl)) & (fan - 1);
          k   = key_at(nd, fan + idx);
          ch  = child_at(nd, idx);
          if (k != 0) cur = k;
          if (ch == 0 || lvl >= 4) break;
          nd = ch;
          lvl++;
        end
        s = cur[KEY_W-1:ROUTE_ID_BITS];
        if (s >= 1 && s <= MAX_SETS) begin
          c = hop_cnt_tab[s-1];
          if (c > 0) begin
            hi           = (s - 1) * MAX_HOPS + it.flow_hash % c;
            r.port_valid = 1'b1;
            r.out_port   = hop_port_tab[hi];
            r.out_gw     = hop_gw_tab[hi];
          end
        end
      end
      OP_INSERT: begin
        if (it.prefix_mask == 0) begin
          prev = default_route;
          if (prev[ROUTE_ID_BITS-1:0] == 0 || it.replace) default_route = newkey;
        end else begin
          rc = expand_prefix(it.dest_addr, it.prefix_mask, newkey, it.replace, 1'b1,
                             1'b1, prev);
          if (rc == ST_POOL_EMPTY) begin
            st   = ST_POOL_EMPTY;
            prev = '0;
          end
        end
        if (st == ST_OK && prev[ROUTE_ID_BITS-1:0] != 0 && !it.replace) st = ST_EXISTS;
      end
      OP_REMOVE: begin
        if (it.prefix_mask == 0) begin
          prev = default_route;
          if (prev[ROUTE_ID_BITS-1:0] != 0) default_route = '0;
          else st = ST_NOT_FOUND;
        end else begin
          rc = expand_prefix(it.dest_addr, it.prefix_mask, '0, 1'b0, 1'b0, 1'b0, prev);
          if (rc != ST_OK || prev[ROUTE_ID_BITS-1:0] == 0) st = ST_NOT_FOUND;
          else rc = expand_prefix(it.dest_addr, it.prefix_mask, '0, 1'b1, 1'b0, 1'b1,
                                  scratch);
        end
      end
      default: begin
        if (it.set_index >= 1 && it.hop_pos < MAX_HOPS) begin
          hi               = (it.set_index - 1) * MAX_HOPS + it.hop_pos;
          hop_gw_tab[hi]   = it.hop_gw;
          hop_port_tab[hi] = it.hop_port;
          hop_cnt_tab[it.set_index-1] = it.hop_count;
        end
      end
    endcase
    r.prev_route_id  = prev[ROUTE_ID_BITS-1:0];
    r.prev_set_index = prev[KEY_W-1:ROUTE_ID_BITS];
    r.status         = st;
    if (st == ST_POOL_EMPTY) pool_full_seen = 1'b1;
    return r;
  endfunction

  task automatic send_request(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t pr;
    pr = route_result(it);
    if (typed) pr = typed_res;
    if (it.op == OP_LOOKUP && pr.port_valid) n_hits++;
    if (it.op == OP_INSERT || it.op == OP_REMOVE) n_updates++;
    if (pr.status == ST_POOL_EMPTY) n_pool_full++;
    n_req++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pending_results.push_back(pr);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic check_result(out_item_t exp_r, out_item_t got);
    if (got.port_valid !== exp_r.port_valid) begin
      $error("port_valid expected %0d got %0d", exp_r.port_valid, got.port_valid);
      errs++;
    end
    if (got.out_port !== exp_r.out_port) begin
      $error("out_port expected %0h got %0h", exp_r.out_port, got.out_port);
      errs++;
    end
    if (got.out_gw !== exp_r.out_gw) begin
      $error("out_gw expected %0h got %0h", exp_r.out_gw, got.out_gw);
      errs++;
    end
    if (got.prev_route_id !== exp_r.prev_route_id) begin
      $error("prev_route_id expected %0h got %0h", exp_r.prev_route_id, got.prev_route_id);
      errs++;
    end
    if (got.prev_set_index !== exp_r.prev_set_index) begin
      $error("prev_set_index expected %0h got %0h", exp_r.prev_set_index,
             got.prev_set_index);
      errs++;
    end
    if (got.status !== exp_r.status) begin
      $error("status expected %0d got %0d", exp_r.status, got.status);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errs++;
      end else begin
        check_result(pending_results.pop_front(), out_data);
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] len_mask(int len);
    return (len == 0) ? 32'd0 : ~32'd0 << (32 - len);
  endfunction

  function automatic logic [31:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return len_mask($urandom_range(4, 7));
    if (r < 18) return len_mask($urandom_range(8, 15));
    if (r < 22) return '0;
    if (r < 27) return $urandom() | 32'h1;
    return len_mask($urandom_range(16, 32));
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    prefix_t  p;
    int       r;
    it.op          = OP_LOOKUP;
    it.dest_addr   = $urandom();
    it.prefix_mask = $urandom();
    it.route_id    = $urandom();
    it.set_index   = ($urandom_range(0, 9) == 0) ? 8'd0 :
                     live_sets[$urandom_range(0, live_sets.size() - 1)];
    it.replace     = $urandom_range(0, 1);
    it.flow_hash   = $urandom();
    it.hop_pos     = $urandom_range(0, MAX_HOPS - 1);
    it.hop_count   = $urandom_range(1, MAX_HOPS);
    it.hop_gw      = $urandom();
    it.hop_port    = $urandom();
    r = $urandom_range(0, 99);
    if (known_prefixes.size() > 0) p = known_prefixes[$urandom_range(0,
                                                       known_prefixes.size() - 1)];
    if (r < 35) begin
      if (known_prefixes.size() > 0 && $urandom_range(0, 9) < 7)
        it.dest_addr = p.addr | ($urandom() & ~p.mask);
    end else if (r < 85) begin
      it.op = (r < 70) ? OP_INSERT : OP_REMOVE;
      if (known_prefixes.size() > 0 && $urandom_range(0, 9) < ((r < 70) ? 3 : 8)) begin
        it.dest_addr   = p.addr;
        it.prefix_mask = p.mask;
      end else begin
        it.prefix_mask = pick_mask();
        it.dest_addr   = it.dest_addr & it.prefix_mask;
        p.addr = it.dest_addr;
        p.mask = it.prefix_mask;
        known_prefixes.push_back(p);
        if (known_prefixes.size() > 48) void'(known_prefixes.pop_front());
      end
    end else if (r < 95) begin
      it.op = OP_HOP_WR;
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) it.set_index = 8'd0;
        else it.hop_pos = 3'd7;
      end else if (it.set_index == 0) begin
        it.set_index = live_sets[0];
      end
    end else begin
      it.op = $urandom_range(0, 1) ? OP_LOOKUP : OP_REMOVE;
    end
    return it;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] op, logic [31:0] addr, logic [31:0] mask,
                                      logic [15:0] rid, logic [7:0] set, bit repl,
                                      logic [31:0] hash, bit typed, out_item_t res);
    dir_row_t row;
    row.req           = '0;
    row.req.op        = op;
    row.req.dest_addr = addr;
    row.req.prefix_mask = mask;
    row.req.route_id  = rid;
    row.req.set_index = set;
    row.req.replace   = repl;
    row.req.flow_hash = hash;
    row.req.hop_count = 3'd1;
    row.typed         = typed;
    row.res           = res;
    return row;
  endfunction

  function automatic out_item_t upd_res(logic [15:0] rid, logic [7:0] set, logic [1:0] st);
    out_item_t r;
    r                = '0;
    r.prev_route_id  = rid;
    r.prev_set_index = set;
    r.status         = st;
    return r;
  endfunction

  initial begin
    in_item_t it;
    int       guard;
    errs           = 0;
    n_req          = 0;
    n_hits         = 0;
    n_updates      = 0;
    n_pool_full    = 0;
    free_node      = 1;
    default_route  = '0;
    idle_on        = 1'b1;
    pool_full_seen = 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    rst_n          <= 1'b0;
    live_sets = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd255,
                  8'd254, 8'd253, 8'd251, 8'd247, 8'd239, 8'd223, 8'd191, 8'd127,
                  8'd170, 8'd85};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every hop of each set in use is written before any route refers to it.
    foreach (live_sets[s]) begin
      for (int p = 0; p < MAX_HOPS; p++) begin
        it           = random_request();
        it.op        = OP_HOP_WR;
        it.set_index = live_sets[s];
        it.hop_pos   = p;
        if (p == MAX_HOPS - 1 && s == 0) it.hop_count = 3'd7;
        send_request(it, 1'b0, '0);
      end
    end

    dir_tab.push_back(mk_row(OP_LOOKUP, 32'h0, 32'h0, 16'h0, 8'd0, 1'b0, 32'h0, 1'b1, '0));
    dir_tab.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 16'h0, 8'd0, 1'b0, 32'h0, 1'b1,
                             upd_res(16'h0, 8'h0, ST_NOT_FOUND)));
    dir_tab.push_back(mk_row(OP_REMOVE, 32'h0a000000, 32'hff000000, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b1, upd_res(16'h0, 8'h0, ST_NOT_FOUND)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0, 32'h0, 16'hffff, 8'd255, 1'b0, 32'h0, 1'b1,
                             upd_res(16'h0, 8'h0, ST_OK)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0, 32'h0, 16'h1234, 8'd1, 1'b0, 32'h0, 1'b1,
                             upd_res(16'hffff, 8'd255, ST_EXISTS)));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'hffffffff, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'hffffffff, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a000000, 32'hff000000, 16'h1, 8'd1, 1'b0,
                             32'h0, 1'b1, upd_res(16'h0, 8'h0, ST_OK)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a000000, 32'hff000000, 16'h5, 8'd3, 1'b0,
                             32'h0, 1'b1, upd_res(16'h1, 8'd1, ST_EXISTS)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a000000, 32'hff000000, 16'h2, 8'd2, 1'b1,
                             32'h0, 1'b1, upd_res(16'h1, 8'd1, ST_OK)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'hffffffff, 32'hffffffff, 16'h8000, 8'd128,
                             1'b0, 32'h0, 1'b1, upd_res(16'h0, 8'h0, ST_OK)));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a010000, 32'hfffff000, 16'h3, 8'd4, 1'b0,
                             32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a010200, 32'hff00ff0f, 16'h7777, 8'd170,
                             1'b0, 32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h0a010200, 32'hffffff00, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'h0a010203, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'h5, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'hffffffff, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'h0a090909, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'hdeadbeef, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_REMOVE, 32'hffffffff, 32'hffffffff, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b1, upd_res(16'h8000, 8'd128, ST_OK)));
    dir_tab.push_back(mk_row(OP_REMOVE, 32'hffffffff, 32'hffffffff, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_HOP_WR, 32'h0, 32'h0, 16'h0, 8'd0, 1'b0, 32'h0, 1'b1,
                             '0));
    dir_tab.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 16'h0, 8'd0, 1'b0, 32'h0, 1'b1,
                             upd_res(16'hffff, 8'd255, ST_OK)));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'h01020304, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'h0, 1'b1, '0));
    dir_tab.push_back(mk_row(OP_INSERT, 32'h80000000, 32'h80000000, 16'h7, 8'd8, 1'b0,
                             32'h0, 1'b0, '0));
    dir_tab.push_back(mk_row(OP_LOOKUP, 32'hc0a80001, 32'h0, 16'h0, 8'd0, 1'b0,
                             32'h3, 1'b0, '0));
    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    // A hop write at an out-of-range position changes nothing.
    it         = random_request();
    it.op      = OP_HOP_WR;
    it.hop_pos = 3'd7;
    send_request(it, 1'b1, '0);

    for (int n = 0; n < 1400; n++) begin
      if (n == 700) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_request(random_request(), 1'b0, '0);
    end

    // Host routes at random addresses until the node pool runs dry or the guard runs out.
    idle_on = 1'b0;
    guard   = 0;
    while (!pool_full_seen && guard < 1500) begin
      it             = random_request();
      it.op          = OP_INSERT;
      it.prefix_mask = 32'hffffffff;
      send_request(it, 1'b0, '0);
      guard++;
    end
    for (int n = 0; n < 40; n++) send_request(random_request(), 1'b0, '0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d requests: %0d route updates, %0d lookups hit a hop set,", n_req,
             n_updates, n_hits);
    $display("%0d inserts refused with the node pool empty.", n_pool_full);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
